### rtl/core/wmd_pkg.sv
`default_nettype none

package wmd_pkg;

   localparam int DEF_WINDOW_SIDE = 5;
   localparam int DEPTH_W         = 16;
   localparam int COORD_W         = 12;
   localparam int LIMIT_W         = 11;
   localparam int CSR_IDX_W       = 8;

   localparam logic [LIMIT_W-1:0] FIRST_LIMIT_RESET  = 11'd480;
   localparam logic [LIMIT_W-1:0] SECOND_LIMIT_RESET = 11'd640;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LIMIT  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_LIMIT = 8'd1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CMP,
      ST_CNT,
      ST_OUT
   } wmd_state_type;

   typedef struct packed {
      logic write_sample;
      logic set_border;
      logic cand_clear;
      logic compare;
      logic cand_next;
      logic set_median;
      logic push_out;
   } wmd_cmd_type;

   typedef struct packed {
      logic last_sample;
      logic border;
      logic hit;
      logic out_free;
   } wmd_status_type;

endpackage

`default_nettype wire

### rtl/core/wmd_datapath.sv
`default_nettype none

module wmd_datapath
   import wmd_pkg::*;
#(
   parameter int WINDOW_SIDE = DEF_WINDOW_SIDE
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wmd_cmd_type          cmd,
   output wmd_status_type            status,
   input  wire logic [DEPTH_W-1:0]   req_depth_sample,
   input  wire logic [COORD_W-1:0]   req_centre_first,
   input  wire logic [COORD_W-1:0]   req_centre_second,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [DEPTH_W-1:0]        rsp_median_depth,
   output logic                      rsp_border_fallback,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_wdata
);

   localparam int N     = WINDOW_SIDE * WINDOW_SIDE;
   localparam int IDX_W = $clog2(N);
   localparam int CNT_W = $clog2(N + 1);
   localparam int HALF  = WINDOW_SIDE / 2;
   localparam int K     = N / 2;
   localparam int EXT_W = COORD_W + 2;

   logic [DEPTH_W-1:0] store_ff [N];
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   cand_idx_ff, cand_idx_in;
   logic [DEPTH_W-1:0] cand_ff;
   logic [DEPTH_W-1:0] cand_val;
   logic [N-1:0]       lt_ff, lt_in;
   logic [N-1:0]       le_ff, le_in;
   logic [CNT_W-1:0]   less_cnt, lesseq_cnt;
   logic [DEPTH_W-1:0] res_ff;
   logic               res_border_ff;
   logic               rsp_valid_ff;
   logic [DEPTH_W-1:0] rsp_median_ff;
   logic               rsp_border_ff;
   logic [LIMIT_W-1:0] first_limit_ff, second_limit_ff;

   logic signed [EXT_W-1:0] cf_ext, cs_ext, first_lim_ext, second_lim_ext, half_ext;
   logic                    border_first, border_second;

   // window store: one write per accepted sample
   always_ff @(posedge clock) begin
      if (cmd.write_sample) begin
         store_ff[cnt_ff] <= req_depth_sample;
      end
   end

   assign cnt_in = (cnt_ff == IDX_W'(N - 1)) ? '0 : cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         cand_idx_ff <= '0;
      end else begin
         if (cmd.write_sample) begin
            cnt_ff <= cnt_in;
         end
         cand_idx_ff <= cand_idx_in;
      end
   end

   always_comb begin
      cand_idx_in = cand_idx_ff;
      if (cmd.cand_clear) begin
         cand_idx_in = '0;
      end else if (cmd.cand_next) begin
         cand_idx_in = cand_idx_ff + 1'b1;
      end
   end

   // rank test of one candidate against every stored sample
   assign cand_val = store_ff[cand_idx_ff];

   always_comb begin
      for (int j = 0; j < N; j++) begin
         lt_in[j] = store_ff[j] <  cand_val;
         le_in[j] = store_ff[j] <= cand_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         lt_ff   <= lt_in;
         le_ff   <= le_in;
         cand_ff <= cand_val;
      end
   end

   assign less_cnt   = CNT_W'($countones(lt_ff));
   assign lesseq_cnt = CNT_W'($countones(le_ff));

   // border test in signed arithmetic wide enough not to wrap
   assign half_ext       = EXT_W'(HALF);
   assign cf_ext         = EXT_W'($signed(req_centre_first));
   assign cs_ext         = EXT_W'($signed(req_centre_second));
   assign first_lim_ext  = $signed({{(EXT_W - LIMIT_W){1'b0}}, first_limit_ff});
   assign second_lim_ext = $signed({{(EXT_W - LIMIT_W){1'b0}}, second_limit_ff});

   assign border_first  = (cf_ext < half_ext) || (cf_ext + half_ext >= first_lim_ext);
   assign border_second = (cs_ext < half_ext) || (cs_ext + half_ext >= second_lim_ext);

   always_ff @(posedge clock) begin
      if (cmd.set_border) begin
         res_ff        <= store_ff[K];
         res_border_ff <= 1'b1;
      end else if (cmd.set_median) begin
         res_ff        <= cand_ff;
         res_border_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_out) begin
         rsp_median_ff <= res_ff;
         rsp_border_ff <= res_border_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_limit_ff  <= FIRST_LIMIT_RESET;
         second_limit_ff <= SECOND_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_LIMIT:  first_limit_ff  <= csr_wdata;
            CSR_SECOND_LIMIT: second_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign status.last_sample = (cnt_ff == IDX_W'(N - 1));
   assign status.border      = border_first || border_second;
   assign status.hit         = (less_cnt <= CNT_W'(K)) && (CNT_W'(K) < lesseq_cnt);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_median_depth    = rsp_median_ff;
   assign rsp_border_fallback = rsp_border_ff;

endmodule

`default_nettype wire

### rtl/core/wmd_ctrl.sv
`default_nettype none

module wmd_ctrl
   import wmd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire wmd_status_type status,
   output wmd_cmd_type         cmd
);

   wmd_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_valid && (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && status.last_sample) begin
               state_in = status.border ? ST_OUT : ST_CMP;
            end
         end
         ST_CMP: state_in = ST_CNT;
         ST_CNT: state_in = status.hit ? ST_OUT : ST_CMP;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall        = 1'b0;
            cmd.write_sample = accept;
            cmd.set_border   = accept && status.last_sample && status.border;
            cmd.cand_clear   = accept && status.last_sample;
         end
         ST_CMP: cmd.compare = 1'b1;
         ST_CNT: begin
            cmd.set_median = status.hit;
            cmd.cand_next  = !status.hit;
         end
         ST_OUT: cmd.push_out = status.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/window_median_depth.sv
// Median filter over a square depth window (5x5 by default).
//
// Input channel (req_*): one depth sample per transaction, window in raster
// order, first coordinate outer. The centre coordinates on the last sample
// of a window are the ones used for the border test.
// Result channel (rsp_*): one transaction per window: the 13th smallest of
// the 25 samples, or the centre sample with rsp_border_fallback set when the
// window crosses the frame border.
// CSR port: index 0 first_coord_limit, index 1 second_coord_limit; always
// ready, other indexes ignored. Write only while the block is idle.
//
// Samples are taken one per cycle while req_stall is low. After the last
// sample the rank search tests one candidate at a time (compare, then
// count), in raster order, until it reaches the first median-valued
// sample; a border window skips the search. req_stall is high from the
// last sample's transaction until the result is in the output register.
// While the receiver stalls, the result holds and the next window is still
// taken; after its last sample the input stalls until the held result leaves.
// Reset clears the sample count, the output valid and restores the limits.
`default_nettype none

module window_median_depth
   import wmd_pkg::*;
#(
   parameter int WINDOW_SIDE = DEF_WINDOW_SIDE
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [DEPTH_W-1:0]   req_depth_sample,
   input  wire logic [COORD_W-1:0]   req_centre_first,
   input  wire logic [COORD_W-1:0]   req_centre_second,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DEPTH_W-1:0]        rsp_median_depth,
   output logic                      rsp_border_fallback,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_wdata
);

   wmd_cmd_type    cmd;
   wmd_status_type status;

   assign csr_ready = 1'b1;

   wmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wmd_datapath #(
      .WINDOW_SIDE (WINDOW_SIDE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_depth_sample    (req_depth_sample),
      .req_centre_first    (req_centre_first),
      .req_centre_second   (req_centre_second),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_median_depth    (rsp_median_depth),
      .rsp_border_fallback (rsp_border_fallback),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

endmodule

`default_nettype wire

### rtl/core/wmd_checker.sv
`default_nettype none

module wmd_checker
   import wmd_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [DEPTH_W-1:0] rsp_median_depth,
   input wire logic               rsp_border_fallback
);

   // after reset the block takes samples and holds no result
   a_reset_state: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   // a result only appears after the input side was held off
   a_result_after_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a completed window");

   // with no result held, rsp_valid stays low in the cycle after an accepted sample
   a_no_accept_push: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> !rsp_valid)
      else $error("result raised while samples were being taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_median_depth) && $stable(rsp_border_fallback)))
      else $error("stalled result changed");

endmodule

bind window_median_depth wmd_checker u_wmd_checker (.*);

`default_nettype wire

### bench/tb_window_median_depth.sv
`default_nettype none

module tb_window_median_depth;
   import wmd_pkg::*;

   localparam int SIDE         = DEF_WINDOW_SIDE;
   localparam int WIN_N        = SIDE * SIDE;
   localparam int HALF         = SIDE / 2;
   localparam int DRAIN_CYCLES = 2 * WIN_N + 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 8'hFF;

   typedef enum {
      PAT_RANDOM,
      PAT_ZERO,
      PAT_FULL,
      PAT_ASCEND,
      PAT_DESCEND,
      PAT_FEW,
      PAT_EXTREMES
   } fill_kind_type;

   typedef struct {
      logic [DEPTH_W-1:0] depth;
      logic               border;
   } depth_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [DEPTH_W-1:0]   req_depth_sample  = '0;
   logic [COORD_W-1:0]   req_centre_first  = '0;
   logic [COORD_W-1:0]   req_centre_second = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   logic [DEPTH_W-1:0]   rsp_median_depth;
   logic                 rsp_border_fallback;
   logic                 csr_valid         = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index         = '0;
   logic [LIMIT_W-1:0]   csr_wdata         = '0;

   // predictor state
   logic [DEPTH_W-1:0] window_copy [WIN_N];
   int                 samples_held = 0;
   logic [LIMIT_W-1:0] first_limit  = FIRST_LIMIT_RESET;
   logic [LIMIT_W-1:0] second_limit = SECOND_LIMIT_RESET;
   depth_result_type   expected_depths [$];

   logic [DEPTH_W-1:0] window_buf [WIN_N];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit steady         = 1'b0;
   int hold_ticket    = 0;
   int hold_seen      = 0;
   int hold_left      = 0;

   window_median_depth DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_depth_sample    (req_depth_sample),
      .req_centre_first    (req_centre_first),
      .req_centre_second   (req_centre_second),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_median_depth    (rsp_median_depth),
      .rsp_border_fallback (rsp_border_fallback),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL window_median_depth");
         $finish;
      end
   end

   // receiver: random stalls unless steady is set, plus a long hold whenever a test asks for one
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 18);
      end
   end

   always @(posedge clock) begin
      depth_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_depths.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
               $display("unexpected result: depth %h border %b",
                        rsp_median_depth, rsp_border_fallback);
         end else begin
            want = expected_depths.pop_front();
            if (rsp_median_depth !== want.depth || rsp_border_fallback !== want.border) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("mismatch: expected depth %h border %b, got depth %h border %b",
                           want.depth, want.border, rsp_median_depth, rsp_border_fallback);
            end
         end
      end
   end

   function automatic logic [DEPTH_W-1:0] rank_median();
      logic [DEPTH_W-1:0] sorted [WIN_N];
      logic [DEPTH_W-1:0] key;
      int j;
      for (int i = 0; i < WIN_N; i++)
         sorted[i] = window_copy[i];
      for (int i = 1; i < WIN_N; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      return sorted[WIN_N / 2];
   endfunction

   function automatic bit crosses_border(input logic [COORD_W-1:0] c_raw,
                                         input logic [LIMIT_W-1:0] lim);
      int c;
      c = $signed(c_raw);
      return (c - HALF < 0) || (c + HALF >= int'(lim));
   endfunction

   // called once per accepted sample; coordinates only matter on the last one
   task automatic predict_window_result(input logic [DEPTH_W-1:0] d,
                                        input logic [COORD_W-1:0] cf,
                                        input logic [COORD_W-1:0] cs);
      depth_result_type res;
      window_copy[samples_held] = d;
      samples_held++;
      if (samples_held == WIN_N) begin
         samples_held = 0;
         res.border = crosses_border(cf, first_limit) || crosses_border(cs, second_limit);
         res.depth  = res.border ? window_copy[WIN_N / 2] : rank_median();
         expected_depths = {expected_depths, res};
      end
   endtask

   task automatic send_sample(input logic [DEPTH_W-1:0] d,
                              input logic [COORD_W-1:0] cf,
                              input logic [COORD_W-1:0] cs);
      if (!steady) begin
         while ($urandom_range(99) < 18) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_depth_sample  <= d;
      req_centre_first  <= cf;
      req_centre_second <= cs;
      do @(posedge clock); while (req_stall);
      predict_window_result(d, cf, cs);
   endtask

   task automatic send_window(input logic [COORD_W-1:0] cf, input logic [COORD_W-1:0] cs);
      for (int i = 0; i < WIN_N - 1; i++)
         send_sample(window_buf[i], COORD_W'($urandom), COORD_W'($urandom));
      send_sample(window_buf[WIN_N - 1], cf, cs);
   endtask

   task automatic fill_window(input fill_kind_type kind);
      logic [DEPTH_W-1:0] base;
      base = DEPTH_W'($urandom);
      for (int i = 0; i < WIN_N; i++) begin
         case (kind)
            PAT_ZERO:     window_buf[i] = '0;
            PAT_FULL:     window_buf[i] = '1;
            PAT_ASCEND:   window_buf[i] = DEPTH_W'(i * 2000 + 7);
            PAT_DESCEND:  window_buf[i] = DEPTH_W'(65535 - i * 1999);
            PAT_FEW:      window_buf[i] = base + DEPTH_W'($urandom_range(3));
            PAT_EXTREMES: window_buf[i] = $urandom_range(1) ? '1 : '0;
            default:      window_buf[i] = DEPTH_W'($urandom);
         endcase
      end
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FIRST_LIMIT)
         first_limit = value;
      else if (idx == CSR_SECOND_LIMIT)
         second_limit = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every window has come back and the rank search is surely done
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_depths.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_inside(input int lim);
      if (lim < 2 * HALF + 1)
         return COORD_W'($urandom);
      return COORD_W'($urandom_range(lim - HALF - 1, HALF));
   endfunction

   function automatic logic [COORD_W-1:0] pick_outside(input int lim);
      int v;
      case ($urandom_range(2))
         0:       v = int'($urandom_range(2047 + HALF)) - 2048;
         1:       v = int'($urandom_range(2047 + HALF - lim)) + lim - HALF;
         default: v = int'($urandom_range(4095));
      endcase
      return COORD_W'(v);
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(7))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd5;
         3:       return 11'd2047;
         default: return LIMIT_W'($urandom_range(2047, 5));
      endcase
   endfunction

   task automatic test_reset_limits();
      fill_window(PAT_ASCEND);   send_window(12'd2, 12'd2);
      fill_window(PAT_DESCEND);  send_window(12'd477, 12'd637);
      fill_window(PAT_FULL);     send_window(12'd240, 12'd320);
      fill_window(PAT_ZERO);     send_window(12'd100, 12'd100);
      fill_window(PAT_FEW);      send_window(12'd50, 12'd600);
      fill_window(PAT_EXTREMES); send_window(12'd300, 12'd20);
      // one window just past each edge
      fill_window(PAT_RANDOM);   send_window(12'd1, 12'd320);
      fill_window(PAT_RANDOM);   send_window(12'd478, 12'd320);
      fill_window(PAT_RANDOM);   send_window(12'd240, 12'd1);
      fill_window(PAT_RANDOM);   send_window(12'd240, 12'd638);
      fill_window(PAT_RANDOM);   send_window(12'h800, 12'h7FF);
      settle();
   endtask

   task automatic test_limit_extremes();
      write_limit(CSR_FIRST_LIMIT, 11'd2047);
      write_limit(CSR_SECOND_LIMIT, 11'd2047);
      fill_window(PAT_RANDOM); send_window(12'd2044, 12'd2044);
      fill_window(PAT_RANDOM); send_window(12'd2045, 12'd2);
      fill_window(PAT_RANDOM); send_window(12'd2, 12'd2045);
      fill_window(PAT_RANDOM); send_window(12'h7FF, 12'h7FF);
      settle();
      // smallest limit that still leaves one interior centre
      write_limit(CSR_FIRST_LIMIT, 11'd5);
      write_limit(CSR_SECOND_LIMIT, 11'd5);
      fill_window(PAT_FEW);    send_window(12'd2, 12'd2);
      fill_window(PAT_RANDOM); send_window(12'd3, 12'd2);
      fill_window(PAT_RANDOM); send_window(12'd2, 12'd3);
      settle();
      // zero and one: every window falls back
      write_limit(CSR_FIRST_LIMIT, 11'd0);
      write_limit(CSR_SECOND_LIMIT, 11'd1);
      fill_window(PAT_RANDOM); send_window(12'd2, 12'd2);
      fill_window(PAT_RANDOM); send_window(12'd100, 12'd0);
      settle();
      write_limit(CSR_FIRST_LIMIT, FIRST_LIMIT_RESET);
      write_limit(CSR_SECOND_LIMIT, SECOND_LIMIT_RESET);
      // writes to unused indexes must leave the limits alone
      write_limit(CSR_UNUSED_LOW, 11'd3);
      write_limit(CSR_UNUSED_HIGH, LIMIT_W'($urandom));
      fill_window(PAT_RANDOM); send_window(12'd477, 12'd637);
      fill_window(PAT_RANDOM); send_window(12'd478, 12'd2);
      settle();
   endtask

   task automatic test_output_hold();
      hold_ticket = hold_ticket + 1;
      for (int w = 0; w < 4; w++) begin
         fill_window(PAT_RANDOM);
         send_window(pick_inside(first_limit), pick_inside(second_limit));
      end
      settle();
   endtask

   task automatic test_random_windows();
      logic [COORD_W-1:0] cf;
      logic [COORD_W-1:0] cs;
      for (int w = 0; w < 40; w++) begin
         if (w % 14 == 0 && w != 0) begin
            settle();
            write_limit(CSR_FIRST_LIMIT, pick_limit());
            write_limit(CSR_SECOND_LIMIT, pick_limit());
         end
         steady = (w >= 20 && w < 34);
         if ($urandom_range(9) < 5)
            fill_window(PAT_RANDOM);
         else
            fill_window(fill_kind_type'($urandom_range(6)));
         case ($urandom_range(9))
            0: begin
               cf = pick_outside(first_limit);
               cs = pick_inside(second_limit);
            end
            1: begin
               cf = pick_inside(first_limit);
               cs = pick_outside(second_limit);
            end
            2: begin
               cf = COORD_W'($urandom);
               cs = COORD_W'($urandom);
            end
            default: begin
               cf = pick_inside(first_limit);
               cs = pick_inside(second_limit);
            end
         endcase
         send_window(cf, cs);
      end
      steady = 1'b0;
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_limits();
      test_limit_extremes();
      test_output_hold();
      test_random_windows();
      if (mismatch_count == 0 && expected_depths.size() == 0) begin
         $display("PASS window_median_depth");
      end else begin
         $display("FAIL window_median_depth");
      end
      $finish;
   end

endmodule

`default_nettype wire
